[sv/multichannel_pwm_with_fade_defines.svh]
// assertion macros for the multichannel pwm block
// used by the top level only, expects clk and arst_n in scope
`ifndef MULTICHANNEL_PWM_WITH_FADE_DEFINES_SVH
`define MULTICHANNEL_PWM_WITH_FADE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PWMF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PWMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pwmf_pkg.sv]
// shared types, codes and constants for the multichannel pwm block
// no dependencies; imported by every module of the block
`default_nettype none

package pwmf_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int OUT_CH = 16;

	// operation codes
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_SET     = 3'd1;
	localparam logic [2:0] OP_PERCENT = 3'd2;
	localparam logic [2:0] OP_POLE    = 3'd3;
	localparam logic [2:0] OP_FADE    = 3'd4;
	localparam logic [2:0] OP_RELEASE = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_DEFAULT_INV = 2'd0;
	localparam logic [1:0] CFG_FADE_NUM    = 2'd1;

	localparam logic [15:0] FADE_NUM_RST = 16'd4080;
	localparam logic [7:0]  DUTY_MAX     = 8'hFF;
	localparam logic [7:0]  PCT_MAX      = 8'd100;
	localparam logic [15:0] PCT_DIVISOR  = 16'd100;
	localparam logic [4:0]  DIV_STEPS    = 5'd16;

	// percent to duty as value * 255 / 100, done as multiply by 10445 / 4096
	// exact floor for every percent up to 100
	localparam logic [13:0] PCT_RECIP = 14'd10445;
	localparam int          PCT_SHIFT = 12;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  channel;
		logic        all_channels;
		logic [7:0]  value;
		logic        hard_restart;
		logic        inverted;
		logic [15:0] fade_up_time;
		logic [15:0] fade_down_time;
	} in_t;

	typedef struct packed {
		logic [15:0] pin_levels;
		logic [15:0] pin_driven;
		logic [7:0]  phase;
	} out_t;

	// per-channel state record
	typedef struct packed {
		logic       active;
		logic       inverted;
		logic [7:0] target;
		logic [7:0] current;
		logic [7:0] rise;
		logic [7:0] fall;
		logic       level;
	} chan_t;

	// controls for the channel update unit
	typedef struct packed {
		logic [2:0] op;
		logic       all;
		logic       hit;
		logic [7:0] duty;
		logic       inv;
		logic [7:0] up;
		logic [7:0] down;
		logic       def_inv;
		logic [7:0] phase;
	} fade_ctl_t;

	typedef struct packed {
		logic        go;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

[sv/multichannel_pwm_with_fade.sv]
// top level of the multichannel pwm generator with fade ramps
// depends on pwmf_pkg, pwmf_div, pwmf_fade and the defines header
//
//  channel   signals                              beat
//  command   start, busy, cmd                     start && !busy
//  result    done, res                            done (one cycle, no backpressure)
//  config    cfg_valid, cfg_ready, cfg_index/data cfg_valid && cfg_ready
//
// tick, set, percent, polarity and release walk the channel records: one channel record
// per cycle through the shared update unit, then a final state to form the result
// percent is scaled by a constant multiply at accept and adds no state
// fade first runs two serial divisions, rise rate then fall rate; unused op codes skip the walk
// reset clears all channel records at once; no clearing pass
// the result strobe is one cycle wide and cannot be held off; cfg_ready is always high
`default_nettype none

`include "multichannel_pwm_with_fade_defines.svh"

module multichannel_pwm_with_fade (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire pwmf_pkg::in_t  cmd,
	output logic                done,
	output pwmf_pkg::out_t      res,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_data
);
	import pwmf_pkg::*;

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// which fade rate the divider is working on
	localparam logic [1:0] DV_UP   = 2'd1;
	localparam logic [1:0] DV_DOWN = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    dsel_q;
	logic          go_q;
	in_t           cmd_q;
	logic [7:0]    phase_q;
	logic [7:0]    duty_q;
	logic [7:0]    up_q;
	logic [7:0]    down_q;
	logic [CH_W-1:0] walk_q;
	logic          def_inv_q;
	logic [15:0]   fade_num_q;
	logic          done_q;
	out_t          res_q;
	chan_t         chan_q [NUM_CHANNELS];

	logic          accept;
	div_req_t      dreq;
	div_rsp_t      drsp;
	fade_ctl_t     fctl;
	chan_t         chan_rd;
	chan_t         chan_wr;
	logic [7:0]    rate;
	logic [15:0]   time_sel;
	logic          last_ch;
	logic [7:0]    pct_duty;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign res       = res_q;

	// config registers, to be written while idle; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_inv_q  <= 1'b0;
			fade_num_q <= FADE_NUM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEFAULT_INV: def_inv_q  <= cfg_data[0];
				CFG_FADE_NUM:    fade_num_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// percent to duty by reciprocal multiply, only used for percents up to 100
	assign pct_duty = 8'(({12'd0, cmd.value} * {6'd0, PCT_RECIP}) >> PCT_SHIFT);

	// divider operands: fade numerator over the selected fade time
	assign time_sel = (dsel_q == DV_UP) ? cmd_q.fade_up_time : cmd_q.fade_down_time;

	always_comb begin
		dreq.go       = go_q;
		dreq.dividend = fade_num_q;
		dreq.divisor  = time_sel;
	end

	// rate saturates to 255, a zero time means jump
	always_comb begin
		if (time_sel == '0)
			rate = '0;
		else if (drsp.quotient[15:8] != '0)
			rate = DUTY_MAX;
		else
			rate = drsp.quotient[7:0];
	end

	pwmf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// one channel record per cycle through the update unit
	assign chan_rd = chan_q[walk_q];
	assign last_ch = (walk_q == CH_W'(NUM_CHANNELS - 1));

	always_comb begin
		fctl.op      = cmd_q.operation;
		fctl.all     = cmd_q.all_channels;
		fctl.hit     = (8'(walk_q) == 8'(cmd_q.channel));
		fctl.duty    = duty_q;
		fctl.inv     = cmd_q.inverted;
		fctl.up      = up_q;
		fctl.down    = down_q;
		fctl.def_inv = def_inv_q;
		fctl.phase   = phase_q;
	end

	pwmf_fade u_fade (
		.cur (chan_rd),
		.ctl (fctl),
		.nxt (chan_wr)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dsel_q  <= DV_UP;
			go_q    <= 1'b0;
			phase_q <= DUTY_MAX;
			walk_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						walk_q <= '0;
						// phase moves at the start of the item
						if (cmd.operation == OP_TICK)
							phase_q <= phase_q + 8'd1;
						else if ((cmd.operation == OP_SET || cmd.operation == OP_PERCENT) &&
							cmd.hard_restart)
							phase_q <= DUTY_MAX;
						priority if (cmd.operation == OP_FADE) begin
							dsel_q  <= DV_UP;
							go_q    <= 1'b1;
							state_q <= ST_DIV;
						end else if (cmd.operation == OP_TICK || cmd.operation == OP_SET ||
							cmd.operation == OP_PERCENT || cmd.operation == OP_POLE ||
							cmd.operation == OP_RELEASE) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						if (dsel_q == DV_UP) begin
							// second division for the fall rate
							dsel_q <= DV_DOWN;
							go_q   <= 1'b1;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					walk_q <= walk_q + CH_W'(1);
					if (last_ch)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command payload and division results
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			if (cmd.operation == OP_PERCENT)
				duty_q <= (cmd.value > PCT_MAX) ? DUTY_MAX : pct_duty;
			else
				duty_q <= cmd.value;
		end
		if (state_q == ST_DIV && drsp.done) begin
			unique case (dsel_q)
				DV_UP:   up_q   <= rate;
				DV_DOWN: down_q <= rate;
				default: begin
				end
			endcase
		end
	end

	// channel records, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++)
				chan_q[i[CH_W-1:0]] <= '0;
		end else if (state_q == ST_WALK) begin
			chan_q[walk_q] <= chan_wr;
		end
	end

	// result beat; released or never used channels idle high
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			for (int i = 0; i < OUT_CH; i++) begin
				if (i < NUM_CHANNELS) begin
					res_q.pin_driven[i[3:0]] <= chan_q[i[CH_W-1:0]].active;
					res_q.pin_levels[i[3:0]] <= chan_q[i[CH_W-1:0]].active ?
						chan_q[i[CH_W-1:0]].level : 1'b1;
				end else begin
					res_q.pin_driven[i[3:0]] <= 1'b0;
					res_q.pin_levels[i[3:0]] <= 1'b0;
				end
			end
			res_q.phase <= phase_q;
		end
	end

	// a result beat only shows once the block is free again
	`PWMF_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
	// an accepted command keeps the block busy
	`PWMF_ASSERT_NXT(a_accept_busy, accept, busy, "accepted command did not start")
	// one result beat per command, the strobe is never held high
	`PWMF_ASSERT_NXT(a_done_single, done, !done, "result strobe held")
	// phase only moves when a command is taken
	`PWMF_ASSERT_NXT(a_phase_hold, busy, $stable(phase_q), "phase moved mid command")

endmodule

`default_nettype wire

[sv/pwmf_div.sv]
// serial restoring divider, one quotient bit per cycle
// depends on pwmf_pkg
`default_nettype none

module pwmf_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pwmf_pkg::div_req_t req,
	output pwmf_pkg::div_rsp_t     rsp
);
	import pwmf_pkg::*;

	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] div_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [17:0] diff;
	logic        neg;

	assign diff = {1'b0, rem_q, quo_q[15]} - {2'b00, div_q};
	assign neg  = diff[17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				cnt_q <= DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 5'd1;
				done_q <= (cnt_q == 5'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= neg ? {rem_q[14:0], quo_q[15]} : diff[15:0];
			quo_q <= {quo_q[14:0], ~neg};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[sv/pwmf_fade.sv]
// channel update unit: applies one operation to one channel record
// depends on pwmf_pkg
`default_nettype none

module pwmf_fade (
	input  wire pwmf_pkg::chan_t     cur,
	input  wire pwmf_pkg::fade_ctl_t ctl,
	output pwmf_pkg::chan_t          nxt
);
	import pwmf_pkg::*;

	logic [8:0] sum;
	logic [7:0] stepped;
	logic [7:0] dec;

	// one fade step toward the target
	always_comb begin
		sum = {1'b0, cur.current} + {1'b0, cur.rise};
		dec = (cur.current >= cur.fall) ? (cur.current - cur.fall) : 8'd0;
		if (cur.target > cur.current && cur.rise != '0) begin
			stepped = (sum > {1'b0, cur.target}) ? cur.target : sum[7:0];
		end else if (cur.target < cur.current && cur.fall != '0) begin
			stepped = (dec < cur.target) ? cur.target : dec;
		end else begin
			stepped = cur.target;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (ctl.op)
			OP_TICK: begin
				if (cur.active) begin
					if (ctl.phase == '0) begin
						nxt.current = stepped;
						nxt.level   = (stepped != '0) ^ cur.inverted;
					end else if (cur.current != '0 && cur.current != DUTY_MAX &&
						cur.current == ctl.phase) begin
						nxt.level = cur.inverted;
					end
				end
			end
			OP_SET, OP_PERCENT: begin
				if (ctl.all) begin
					if (cur.active)
						nxt.target = ctl.duty;
				end else if (ctl.hit) begin
					if (!cur.active) begin
						nxt.active   = 1'b1;
						nxt.inverted = ctl.def_inv;
						nxt.level    = ctl.def_inv;
					end
					nxt.target = ctl.duty;
				end
			end
			OP_POLE: begin
				if (cur.active && (ctl.all || ctl.hit))
					nxt.inverted = ctl.inv;
			end
			OP_FADE: begin
				if (cur.active && (ctl.all || ctl.hit)) begin
					nxt.rise = ctl.up;
					nxt.fall = ctl.down;
				end
			end
			OP_RELEASE: begin
				if (cur.active && ctl.hit) begin
					nxt.active   = 1'b0;
					nxt.inverted = 1'b0;
					nxt.rise     = '0;
					nxt.fall     = '0;
					nxt.level    = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

[dv/multichannel_pwm_with_fade_test.sv]
// self-checking testbench for the multichannel pwm generator with fade ramps
// depends on pwmf_pkg and the multichannel_pwm_with_fade top level; carries its own pwm predictor
`timescale 1ns / 100ps

module multichannel_pwm_with_fade_test;

	import pwmf_pkg::*;

	// the two unused operation codes still produce a result beat
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// longest legal quiet stretch is a fade beat plus a sender gap
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         cmd;
	logic        done;
	out_t        res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	multichannel_pwm_with_fade dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted pin state, one entry per accepted command beat
	out_t pending_pins[$];
	out_t oldest_pins;

	// predictor copy of the registers
	logic        cfg_def_inv;
	logic [15:0] cfg_fade_num;

	// predictor copy of the phase counter and channel records
	logic [7:0] mdl_phase;
	logic       mdl_active [NUM_CHANNELS];
	logic       mdl_inv    [NUM_CHANNELS];
	logic [7:0] mdl_target [NUM_CHANNELS];
	logic [7:0] mdl_duty   [NUM_CHANNELS];
	logic [7:0] mdl_rise   [NUM_CHANNELS];
	logic [7:0] mdl_fall   [NUM_CHANNELS];
	logic       mdl_level  [NUM_CHANNELS];

	int mismatch_count;
	int results_checked;
	int cmd_count;
	int tick_count;
	int wrap_count;
	int cfg_write_count;
	int stall_cycles;

	// free-running clock, 20 ns period
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// power-on state of the predictor
	task automatic reset_model;
		cfg_def_inv = 1'b0;
		cfg_fade_num = FADE_NUM_RST;
		mdl_phase = '1;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			mdl_active[i] = 1'b0;
			mdl_inv[i] = 1'b0;
			mdl_target[i] = '0;
			mdl_duty[i] = '0;
			mdl_rise[i] = '0;
			mdl_fall[i] = '0;
			mdl_level[i] = 1'b0;
		end
	endtask

	// ramp step per period from a fade time, zero time means jump
	function automatic logic [7:0] fade_rate(input logic [15:0] ms);
		logic [15:0] q;
		if (ms == 16'd0)
			return 8'd0;
		q = cfg_fade_num / ms;
		return (q > 16'(DUTY_MAX)) ? DUTY_MAX : q[7:0];
	endfunction

	// apply one command to the predictor and return the pin state it leaves
	function automatic out_t advance_pwm(input in_t c);
		logic [7:0] duty;
		logic [7:0] up_rate;
		logic [7:0] down_rate;
		int pct;
		int cur;
		int tgt;
		int nv;
		out_t r;
		up_rate = fade_rate(c.fade_up_time);
		down_rate = fade_rate(c.fade_down_time);
		r = '0;
		case (c.operation)
		OP_TICK: begin
			mdl_phase = mdl_phase + 8'd1;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (!mdl_active[i])
					continue;
				if (mdl_phase == 8'd0) begin
					// period start: ramp toward target, clamped there
					cur = int'(mdl_duty[i]);
					tgt = int'(mdl_target[i]);
					nv = tgt;
					if (tgt > cur && mdl_rise[i] != 8'd0) begin
						nv = cur + int'(mdl_rise[i]);
						if (nv > tgt)
							nv = tgt;
					end else if (tgt < cur && mdl_fall[i] != 8'd0) begin
						nv = (cur >= int'(mdl_fall[i])) ? cur - int'(mdl_fall[i]) : 0;
						if (nv < tgt)
							nv = tgt;
					end
					mdl_duty[i] = nv[7:0];
					mdl_level[i] = (mdl_duty[i] != 8'd0) ^ mdl_inv[i];
				end else if (mdl_duty[i] != 8'd0 && mdl_duty[i] != DUTY_MAX &&
						mdl_duty[i] == mdl_phase) begin
					mdl_level[i] = mdl_inv[i];
				end
			end
		end
		OP_SET, OP_PERCENT: begin
			if (c.operation == OP_SET) begin
				duty = c.value;
			end else if (c.value > PCT_MAX) begin
				duty = DUTY_MAX;
			end else begin
				pct = int'(c.value);
				pct = pct * int'(DUTY_MAX) / int'(PCT_DIVISOR);
				duty = pct[7:0];
			end
			if (c.all_channels) begin
				for (int i = 0; i < NUM_CHANNELS; i++)
					if (mdl_active[i])
						mdl_target[i] = duty;
			end else begin
				// first set on a channel brings it up at the default polarity, level off
				if (!mdl_active[c.channel]) begin
					mdl_active[c.channel] = 1'b1;
					mdl_inv[c.channel] = cfg_def_inv;
					mdl_level[c.channel] = cfg_def_inv;
				end
				mdl_target[c.channel] = duty;
			end
			if (c.hard_restart)
				mdl_phase = '1;
		end
		OP_POLE, OP_FADE: begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (!mdl_active[i] || (!c.all_channels && i != int'(c.channel)))
					continue;
				if (c.operation == OP_POLE) begin
					mdl_inv[i] = c.inverted;
				end else begin
					mdl_rise[i] = up_rate;
					mdl_fall[i] = down_rate;
				end
			end
		end
		OP_RELEASE: begin
			// all_channels plays no part here; duties survive the release
			if (mdl_active[c.channel]) begin
				mdl_active[c.channel] = 1'b0;
				mdl_inv[c.channel] = 1'b0;
				mdl_rise[c.channel] = '0;
				mdl_fall[c.channel] = '0;
				mdl_level[c.channel] = 1'b1;
			end
		end
		default: begin
		end
		endcase
		for (int i = 0; i < NUM_CHANNELS && i < OUT_CH; i++) begin
			if (mdl_active[i]) begin
				r.pin_driven[i] = 1'b1;
				r.pin_levels[i] = mdl_level[i];
			end else begin
				// released or never used channels idle high
				r.pin_levels[i] = 1'b1;
			end
		end
		r.phase = mdl_phase;
		return r;
	endfunction

	function automatic in_t make_cmd(input logic [2:0] op, input logic [3:0] ch,
			input logic all, input logic [7:0] value, input logic hard,
			input logic inv, input logic [15:0] up_ms, input logic [15:0] down_ms);
		in_t c;
		c.operation = op;
		c.channel = ch;
		c.all_channels = all;
		c.value = value;
		c.hard_restart = hard;
		c.inverted = inv;
		c.fade_up_time = up_ms;
		c.fade_down_time = down_ms;
		return c;
	endfunction

	// random command: noise in every field, then shaped toward useful values
	function automatic in_t draw_cmd();
		logic [63:0] noise;
		in_t c;
		int pick;
		noise = {$urandom, $urandom};
		c = noise[$bits(in_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 58)
			c.operation = OP_TICK;
		else if (pick < 70)
			c.operation = OP_SET;
		else if (pick < 77)
			c.operation = OP_PERCENT;
		else if (pick < 83)
			c.operation = OP_POLE;
		else if (pick < 90)
			c.operation = OP_FADE;
		else if (pick < 96)
			c.operation = OP_RELEASE;
		else
			c.operation = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
		c.all_channels = ($urandom_range(0, 4) == 0);
		c.hard_restart = ($urandom_range(0, 19) == 0);
		if (c.operation == OP_SET) begin
			// edge duties, duties near either end of the period, and any duty
			case ($urandom_range(0, 3))
			0: c.value = $urandom_range(0, 1) ? DUTY_MAX : 8'd0;
			1: c.value = 8'($urandom_range(1, 24));
			2: c.value = 8'($urandom_range(230, 254));
			default: c.value = 8'($urandom_range(0, 255));
			endcase
		end else if (c.operation == OP_PERCENT && $urandom_range(0, 3) != 0) begin
			c.value = 8'($urandom_range(0, 110));
		end
		case ($urandom_range(0, 3))
		0: c.fade_up_time = 16'd0;
		1: c.fade_up_time = 16'($urandom_range(1, 40));
		2: c.fade_up_time = 16'($urandom_range(41, 4095));
		default: c.fade_up_time = 16'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 3))
		0: c.fade_down_time = 16'd0;
		1: c.fade_down_time = 16'($urandom_range(1, 40));
		2: c.fade_down_time = 16'($urandom_range(41, 4095));
		default: c.fade_down_time = 16'($urandom_range(0, 65535));
		endcase
		return c;
	endfunction

	// one command beat; start is left high so a following beat can go back to back
	task automatic send_cmd(input in_t c);
		@(negedge clk);
		cmd = c;
		start = 1'b1;
		do @(posedge clk); while (busy);
		pending_pins.push_back(advance_pwm(c));
		cmd_count++;
		if (c.operation == OP_TICK) begin
			tick_count++;
			if (mdl_phase == 8'd0)
				wrap_count++;
		end
	endtask

	// occasional sender gap of idle cycles with start low, sometimes placed after busy drops
	task automatic sender_gap;
		int n;
		if ($urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 4);
			@(negedge clk);
			start = 1'b0;
			if ($urandom_range(0, 1))
				do @(posedge clk); while (busy);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold off until every predicted beat has come back and the block is idle
	task automatic wait_quiet;
		@(negedge clk);
		start = 1'b0;
		do @(posedge clk); while (pending_pins.size() != 0 || busy);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		start = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_DEFAULT_INV)
			cfg_def_inv = data[0];
		else if (idx == CFG_FADE_NUM)
			cfg_fade_num = data;
		cfg_write_count++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic retune(input logic def_inv, input logic [15:0] fade_num);
		wait_quiet();
		write_reg(CFG_DEFAULT_INV, {15'd0, def_inv});
		write_reg(CFG_FADE_NUM, fade_num);
	endtask

	// first tick out of reset wraps the phase with no channel active
	task automatic test_first_tick;
		send_cmd(make_cmd(OP_TICK, 4'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
	endtask

	// duty and percent at their edges, single channel and broadcast
	task automatic test_set_and_percent;
		send_cmd(make_cmd(OP_SET, 4'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_SET, 4'd15, 1'b0, DUTY_MAX, 1'b1, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_PERCENT, 4'd3, 1'b0, 8'd50, 1'b0, 1'b0, 16'd0, 16'd0));
		// over 100 percent saturates to full duty
		send_cmd(make_cmd(OP_PERCENT, 4'd4, 1'b0, 8'd101, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_PERCENT, 4'd5, 1'b0, PCT_MAX, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_PERCENT, 4'd6, 1'b0, 8'd255, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF));
		// broadcast only retargets channels already up
		send_cmd(make_cmd(OP_SET, 4'd9, 1'b1, 8'd1, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_SET, 4'd1, 1'b0, 8'd128, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_TICK, 4'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_TICK, 4'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
	endtask

	// polarity and fade, including idle channels that must ignore them
	task automatic test_polarity_and_fade;
		send_cmd(make_cmd(OP_POLE, 4'd0, 1'b1, 8'd0, 1'b0, 1'b1, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_POLE, 4'd9, 1'b0, 8'd0, 1'b0, 1'b1, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_POLE, 4'd3, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
		// shortest up time saturates the rate, longest down time truncates to zero
		send_cmd(make_cmd(OP_FADE, 4'd3, 1'b0, 8'd0, 1'b0, 1'b0, 16'd1, 16'hFFFF));
		send_cmd(make_cmd(OP_FADE, 4'd7, 1'b0, 8'd0, 1'b0, 1'b0, 16'd5, 16'd5));
		send_cmd(make_cmd(OP_FADE, 4'd0, 1'b1, 8'd0, 1'b0, 1'b0, 16'd16, 16'd0));
		send_cmd(make_cmd(OP_SET, 4'd1, 1'b0, DUTY_MAX, 1'b1, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_TICK, 4'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
	endtask

	// release, repeated release, spare codes, and re-activation at inverted default
	task automatic test_release_and_spare;
		retune(1'b1, FADE_NUM_RST);
		send_cmd(make_cmd(OP_RELEASE, 4'd15, 1'b1, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_RELEASE, 4'd15, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_SPARE_6, 4'd1, 1'b1, 8'hA5, 1'b1, 1'b1, 16'h5A5A, 16'hA5A5));
		send_cmd(make_cmd(OP_SPARE_7, 4'd2, 1'b0, 8'h5A, 1'b1, 1'b0, 16'hFFFF, 16'h0001));
		send_cmd(make_cmd(OP_SET, 4'd15, 1'b0, 8'd200, 1'b0, 1'b0, 16'd0, 16'd0));
		send_cmd(make_cmd(OP_TICK, 4'd0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
	endtask

	// random traffic with occasional long tick runs so phases climb past the low duties
	task automatic test_random_traffic(input int n_items, input bit gaps, input bit pause_midway);
		in_t c;
		int tick_run;
		tick_run = 0;
		for (int k = 0; k < n_items; k++) begin
			c = draw_cmd();
			if (tick_run > 0) begin
				c.operation = OP_TICK;
				tick_run--;
			end else if ($urandom_range(0, 99) < 3) begin
				tick_run = $urandom_range(40, 120);
			end
			send_cmd(c);
			if (gaps)
				sender_gap();
			if (pause_midway && k == n_items / 2)
				wait_quiet();
		end
	endtask

	// result checker: each done beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pins.size() == 0) begin
				$error("result beat with nothing outstanding: levels %h driven %h phase %0d",
					res.pin_levels, res.pin_driven, res.phase);
				mismatch_count++;
			end else begin
				oldest_pins = pending_pins.pop_front();
				results_checked++;
				if (res.pin_levels !== oldest_pins.pin_levels) begin
					$error("pin_levels: expected %h, got %h",
						oldest_pins.pin_levels, res.pin_levels);
					mismatch_count++;
				end
				if (res.pin_driven !== oldest_pins.pin_driven) begin
					$error("pin_driven: expected %h, got %h",
						oldest_pins.pin_driven, res.pin_driven);
					mismatch_count++;
				end
				if (res.phase !== oldest_pins.phase) begin
					$error("phase: expected %0d, got %0d", oldest_pins.phase, res.phase);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: counts cycles with no command, result or config beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		results_checked = 0;
		cmd_count = 0;
		tick_count = 0;
		wrap_count = 0;
		cfg_write_count = 0;
		stall_cycles = 0;
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at reset register values, but for an inverted default polarity in the release test
		test_first_tick();
		test_set_and_percent();
		test_polarity_and_fade();
		test_release_and_spare();

		// random part across register settings, extremes first
		retune(1'b1, 16'hFFFF);
		test_random_traffic(200, 1'b1, 1'b0);
		retune(1'b0, 16'h0000);
		test_random_traffic(150, 1'b1, 1'b1);
		retune(1'($urandom_range(0, 1)), 16'($urandom_range(1, 65534)));
		test_random_traffic(150, 1'b1, 1'b0);
		// closing stretch runs back to back with no sender gaps
		retune(1'b0, FADE_NUM_RST);
		test_random_traffic(125, 1'b0, 1'b0);

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_pins.size() != 0) begin
			$error("%0d predicted result beats never arrived", pending_pins.size());
			mismatch_count++;
		end

		$display("run covered %0d commands (%0d ticks, %0d period wraps), %0d results checked",
			cmd_count, tick_count, wrap_count, results_checked);
		$display("with %0d register writes over default polarity and fade numerator extremes",
			cfg_write_count);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
